@@ hw/rtl/bitmap_next_fit_allocator_unit_assert.svh @@
// Assertion macros for the bitmap next-fit allocator.
// Included by bitmap_next_fit_allocator_unit.sv; expects aclk and aresetn in scope.
`ifndef BITMAP_NEXT_FIT_ALLOCATOR_UNIT_ASSERT_SVH
`define BITMAP_NEXT_FIT_ALLOCATOR_UNIT_ASSERT_SVH

// same-cycle implication
`define BNFA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BNFA_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/bnfa_pkg.sv @@
// Shared constants and beat types of the bitmap next-fit allocator.
// No dependencies.
package bnfa_pkg;

    localparam int MAP_UNITS_DEF = 1024;
    localparam int WORD_W        = 32;
    localparam int WORD_LOG      = 5;
    localparam int SIZE_W        = 11;
    localparam int OFFS_W        = 10;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef struct packed {
        logic              operation;
        logic [SIZE_W-1:0] request_size;
        logic [OFFS_W-1:0] free_offset;
    } req_beat_t;

    typedef struct packed {
        logic              success;
        logic [OFFS_W-1:0] alloc_offset;
    } rsp_beat_t;

endpackage

@@ hw/rtl/bitmap_next_fit_allocator_unit.sv @@
// Bitmap next-fit allocator: occupancy map in a word memory, scan and mark sequencer.
// Depends on bnfa_pkg and bitmap_next_fit_allocator_unit_assert.svh.
//
// Usage: one request beat on s_valid/s_ready (allocate or free a run of units),
// one response beat on m_valid/m_ready per request (success, first allocated unit).
// The map is kept as 32-bit rows in a single-port-write, registered-read memory;
// a per-row valid bit makes every row read as free after reset, so no clearing
// pass is needed and the unit is ready as soon as reset is released.
// An allocate scans from the next-fit pointer: each row is read (ST_SC_RD), then
// examined (ST_SC_EX), with a further examine step for each extra used/free
// segment inside the row, bounded by the priority-encoder step that finds the
// next used unit. Marking or freeing is a read (ST_WR_RD) and a write-back
// (ST_WR_EX) per touched row. A fragmented map needs more steps than an empty one.
// s_ready is high only while idle; one request is in flight at a time, and it may
// be accepted while the previous response still waits. When m_ready is low the
// response register holds and the next finished result waits in the sequencer.
// Reset (aresetn low, synchronous) frees every unit and zeroes the pointer.
module bitmap_next_fit_allocator_unit #(
    parameter int MAP_UNITS = bnfa_pkg::MAP_UNITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  bnfa_pkg::req_beat_t s_beat,
    output logic                m_valid,
    input  logic                m_ready,
    output bnfa_pkg::rsp_beat_t m_beat
);

`include "bitmap_next_fit_allocator_unit_assert.svh"

    localparam int IDX_W = (MAP_UNITS > 1) ? $clog2(MAP_UNITS) : 1;
    localparam int CNT_W = IDX_W + 1;
    localparam int CMP_W = ((CNT_W > bnfa_pkg::SIZE_W) ? CNT_W : bnfa_pkg::SIZE_W) + 1;
    localparam int WW    = bnfa_pkg::WORD_W;
    localparam int WL    = bnfa_pkg::WORD_LOG;
    localparam int ROWS  = (MAP_UNITS + WW - 1) / WW;
    localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int TZ_W  = WL + 1;

    localparam logic [CMP_W-1:0] N_C    = CMP_W'(MAP_UNITS);
    localparam logic [CMP_W-1:0] ONE_C  = CMP_W'(1);
    localparam logic [CMP_W-1:0] WORD_C = CMP_W'(WW);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SC_RD  = 3'd1;
    localparam logic [2:0] ST_SC_EX  = 3'd2;
    localparam logic [2:0] ST_FB     = 3'd3;
    localparam logic [2:0] ST_WR_RD  = 3'd4;
    localparam logic [2:0] ST_WR_EX  = 3'd5;
    localparam logic [2:0] ST_RESULT = 3'd6;

    function automatic logic [ROW_W-1:0] row_of(input logic [CMP_W-1:0] x);
        row_of = ROW_W'(x >> WL);
    endfunction

    function automatic logic [TZ_W-1:0] tz_count(input logic [WW-1:0] v);
        logic [TZ_W-1:0] r;
        r = TZ_W'(WW);
        for (int i = WW - 1; i >= 0; i--) begin
            if (v[i]) begin
                r = TZ_W'(i);
            end
        end
        return r;
    endfunction

    logic [2:0]                state_reg, state_next;
    logic [CMP_W-1:0]          p_reg, p_next;
    logic [CMP_W-1:0]          lim_reg, lim_next;
    logic [CMP_W-1:0]          start_reg, start_next;
    logic [CMP_W-1:0]          run_reg, run_next;
    logic [CMP_W-1:0]          lead_reg, lead_next;
    logic                      lead_vld_reg, lead_vld_next;
    logic [CMP_W-1:0]          size_reg, size_next;
    logic [CMP_W-1:0]          q_reg, q_next;
    logic [CMP_W-1:0]          qend_reg, qend_next;
    logic                      set_reg, set_next;
    logic                      ok_reg, ok_next;
    logic [bnfa_pkg::OFFS_W-1:0] off_reg, off_next;
    logic [IDX_W-1:0]          ptr_reg, ptr_next;
    logic                      m_valid_reg, m_valid_next;
    bnfa_pkg::rsp_beat_t       m_beat_reg, m_beat_next;

    logic [WW-1:0]             mem [ROWS];
    logic [ROWS-1:0]           row_vld_reg;
    logic [WW-1:0]             rd_data_reg;
    logic                      rd_vld_reg;
    logic [ROW_W-1:0]          rd_addr;
    logic                      we;

    logic [WW-1:0]             word;
    logic [WL-1:0]             bit_sel;
    logic [2*WW-1:0]           shifted;
    logic [TZ_W-1:0]           tz;
    logic [CMP_W-1:0]          tz_c, room, rem, z, sum, adv;
    logic                      one_hit, hit;
    logic [CMP_W-1:0]          mark_base, mark_end, free_end;
    logic                      fb_fit;

    logic [CMP_W-1:0]          row_base, span, hi;
    logic [WL-1:0]             lo;
    logic [WW-1:0]             wr_mask, wr_word;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_beat  = m_beat_reg;

    assign rd_addr = (state_reg == ST_WR_RD || state_reg == ST_WR_EX) ? row_of(q_reg)
                                                                      : row_of(p_reg);
    assign word    = rd_vld_reg ? rd_data_reg : '0;

    // scan step: free units from the current position up to the next used unit
    assign bit_sel = WL'(p_reg);
    assign shifted = {{WW{1'b1}}, word} >> bit_sel;
    assign tz      = tz_count(shifted[WW-1:0]);
    assign tz_c    = CMP_W'(tz);
    assign room    = WORD_C - CMP_W'(bit_sel);
    assign rem     = lim_reg - p_reg;
    assign z       = (tz_c < rem) ? tz_c : rem;
    assign one_hit = (tz_c < rem) && (tz_c < room);
    assign sum     = run_reg + z;
    assign hit     = (sum >= size_reg);

    assign mark_base = ((state_reg == ST_FB) ? start_reg : p_reg) - run_reg;
    assign mark_end  = mark_base + size_reg;
    assign fb_fit    = lead_vld_reg && ((lead_reg + run_reg) >= size_reg);
    assign free_end  = CMP_W'(s_beat.free_offset) + CMP_W'(s_beat.request_size);

    // row read-modify-write
    assign row_base = q_reg & ~CMP_W'(WW - 1);
    assign lo       = WL'(q_reg);
    assign span     = qend_reg - row_base;
    assign hi       = (span < WORD_C) ? span : WORD_C;
    assign wr_mask  = ~({WW{1'b1}} << hi) & ({WW{1'b1}} << lo);
    assign wr_word  = set_reg ? (word | wr_mask) : (word & ~wr_mask);

    always_comb begin
        state_next    = state_reg;
        p_next        = p_reg;
        lim_next      = lim_reg;
        start_next    = start_reg;
        run_next      = run_reg;
        lead_next     = lead_reg;
        lead_vld_next = lead_vld_reg;
        size_next     = size_reg;
        q_next        = q_reg;
        qend_next     = qend_reg;
        set_next      = set_reg;
        ok_next       = ok_reg;
        off_next      = off_reg;
        ptr_next      = ptr_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_beat_next   = m_beat_reg;
        adv           = p_reg;
        we            = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    size_next = CMP_W'(s_beat.request_size);
                    ok_next   = 1'b0;
                    off_next  = '0;
                    if (s_beat.request_size == '0) begin
                        state_next = ST_RESULT;
                    end else if (s_beat.operation == bnfa_pkg::OP_ALLOC) begin
                        p_next        = CMP_W'(ptr_reg);
                        start_next    = CMP_W'(ptr_reg);
                        lim_next      = N_C;
                        run_next      = '0;
                        lead_vld_next = 1'b0;
                        state_next    = ST_SC_RD;
                    end else begin
                        ok_next    = 1'b1;
                        set_next   = 1'b0;
                        q_next     = CMP_W'(s_beat.free_offset);
                        qend_next  = (free_end < N_C) ? free_end : N_C;
                        state_next = (CMP_W'(s_beat.free_offset) < N_C) ? ST_WR_RD : ST_RESULT;
                    end
                end
            end
            ST_SC_RD: begin
                state_next = ST_SC_EX;
            end
            ST_SC_EX: begin
                if (hit) begin
                    ptr_next   = (mark_end == N_C) ? '0 : IDX_W'(mark_end);
                    q_next     = mark_base;
                    qend_next  = mark_end;
                    set_next   = 1'b1;
                    ok_next    = 1'b1;
                    off_next   = bnfa_pkg::OFFS_W'(mark_base);
                    state_next = ST_WR_RD;
                end else begin
                    if (one_hit) begin
                        if (!lead_vld_reg) begin
                            lead_next     = sum;
                            lead_vld_next = 1'b1;
                        end
                        run_next = '0;
                        adv      = p_reg + z + ONE_C;
                    end else begin
                        run_next = sum;
                        adv      = p_reg + z;
                    end
                    if (adv == lim_reg) begin
                        if (lim_reg == N_C) begin
                            if (!lead_vld_next) begin
                                lead_next     = run_next;
                                lead_vld_next = 1'b1;
                            end
                            run_next   = '0;
                            p_next     = '0;
                            lim_next   = start_reg;
                            state_next = (start_reg == '0) ? ST_FB : ST_SC_RD;
                        end else begin
                            p_next     = adv;
                            state_next = ST_FB;
                        end
                    end else begin
                        p_next     = adv;
                        state_next = (row_of(adv) != row_of(p_reg)) ? ST_SC_RD : ST_SC_EX;
                    end
                end
            end
            ST_FB: begin
                if (fb_fit) begin
                    ptr_next   = (mark_end == N_C) ? '0 : IDX_W'(mark_end);
                    q_next     = mark_base;
                    qend_next  = mark_end;
                    set_next   = 1'b1;
                    ok_next    = 1'b1;
                    off_next   = bnfa_pkg::OFFS_W'(mark_base);
                    state_next = ST_WR_RD;
                end else begin
                    ok_next    = 1'b0;
                    off_next   = '0;
                    state_next = ST_RESULT;
                end
            end
            ST_WR_RD: begin
                state_next = ST_WR_EX;
            end
            ST_WR_EX: begin
                we         = 1'b1;
                q_next     = row_base + WORD_C;
                state_next = ((row_base + WORD_C) >= qend_reg) ? ST_RESULT : ST_WR_RD;
            end
            ST_RESULT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next             = 1'b1;
                    m_beat_next.success      = ok_reg;
                    m_beat_next.alloc_offset = off_reg;
                    state_next               = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            ptr_reg     <= '0;
            row_vld_reg <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            ptr_reg     <= ptr_next;
            if (we) begin
                row_vld_reg[row_of(q_reg)] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        p_reg        <= p_next;
        lim_reg      <= lim_next;
        start_reg    <= start_next;
        run_reg      <= run_next;
        lead_reg     <= lead_next;
        lead_vld_reg <= lead_vld_next;
        size_reg     <= size_next;
        q_reg        <= q_next;
        qend_reg     <= qend_next;
        set_reg      <= set_next;
        ok_reg       <= ok_next;
        off_reg      <= off_next;
        m_beat_reg   <= m_beat_next;
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[row_of(q_reg)] <= wr_word;
        end
        rd_data_reg <= mem[rd_addr];
        rd_vld_reg  <= row_vld_reg[rd_addr];
    end

    `BNFA_ASSERT_NXT(a_busy_after_accept, s_valid && s_ready, !s_ready, "unit still ready after accepting a beat")
    `BNFA_ASSERT_NOW(a_scan_bounds, state_reg == ST_SC_RD || state_reg == ST_SC_EX, (p_reg < lim_reg) && (run_reg < size_reg), "scan position or run out of bounds")
    `BNFA_ASSERT_NOW(a_write_span, state_reg == ST_WR_RD, (q_reg < qend_reg) && (qend_reg <= N_C), "empty or oversized write span")
    `BNFA_ASSERT_NOW(a_ptr_range, 1'b1, CMP_W'(ptr_reg) < N_C, "next-fit pointer past end of map")
    `BNFA_ASSERT_NXT(a_result_loaded, state_reg == ST_RESULT && (!m_valid_reg || m_ready), m_valid && s_ready, "finished result not presented")

endmodule

@@ dv/tb_top.sv @@
// Self-checking bench for bitmap_next_fit_allocator_unit: a directed table, then random
// allocate/free traffic, every response scored against its table row or the bench model.
// Depends on bnfa_pkg and the RTL of the unit.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int UNITS        = bnfa_pkg::MAP_UNITS_DEF;
    localparam int RANDOM_ITEMS = 1525;
    localparam int CYCLE_LIMIT  = 15_000_000;
    localparam int HOLD_CYCLES  = 600;
    localparam int DRAIN_CYCLES = 2500;

    typedef struct {
        bnfa_pkg::req_beat_t req;
        bit                  typed;
        bnfa_pkg::rsp_beat_t want;
    } dir_row_t;

    typedef struct {
        int base;
        int len;
    } live_run_t;

    logic                aclk;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    bnfa_pkg::req_beat_t s_beat;
    logic                m_valid;
    logic                m_ready;
    bnfa_pkg::rsp_beat_t m_beat;

    bit [UNITS-1:0]      occ_map;
    int                  fit_ptr;
    live_run_t           live_runs[$];
    bnfa_pkg::rsp_beat_t rsp_expect[$];
    dir_row_t            directed_rows[$];

    int  mismatches;
    int  results_seen;
    int  cycles;
    int  allocs_ok;
    int  allocs_failed;
    int  joined_allocs;
    int  frees_done;
    bit  quiet;

    bitmap_next_fit_allocator_unit #(.MAP_UNITS(UNITS)) DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_beat  (s_beat),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_beat  (m_beat)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    function automatic bnfa_pkg::rsp_beat_t predict_beat(input bnfa_pkg::req_beat_t b);
        bnfa_pkg::rsp_beat_t r;
        int size, off, start, curr, run, lead, base, i;
        bit lead_seen, found;
        r = '0;
        size = int'(b.request_size);
        off = int'(b.free_offset);
        if (b.operation == bnfa_pkg::OP_FREE) begin
            if (size != 0) begin
                for (i = off; i < off + size && i < UNITS; i++) occ_map[i] = 1'b0;
                r.success = 1'b1;
                frees_done++;
            end
            return r;
        end
        if (size == 0) begin
            allocs_failed++;
            return r;
        end
        start = fit_ptr;
        curr = start;
        run = 0;
        lead = 0;
        base = 0;
        lead_seen = 1'b0;
        found = 1'b0;
        do begin
            if (!occ_map[curr]) begin
                run++;
            end else begin
                if (!lead_seen) begin
                    lead = run;
                    lead_seen = 1'b1;
                end
                run = 0;
            end
            if (run == size) begin
                base = curr + 1 - size;
                fit_ptr = (curr + 1) % UNITS;
                found = 1'b1;
                break;
            end
            curr++;
            if (curr >= UNITS) begin
                if (!lead_seen) begin
                    lead = run;
                    lead_seen = 1'b1;
                end
                run = 0;
                curr = 0;
            end
        end while (curr != start);
        if (!found && lead_seen && lead + run >= size && run <= start) begin
            base = start - run;
            fit_ptr = (base + size) % UNITS;
            found = 1'b1;
            joined_allocs++;
        end
        if (found) begin
            for (i = base; i < base + size && i < UNITS; i++) occ_map[i] = 1'b1;
            r.success = 1'b1;
            r.alloc_offset = bnfa_pkg::OFFS_W'(base);
            live_runs.push_back('{base: base, len: size});
            allocs_ok++;
        end else begin
            allocs_failed++;
        end
        return r;
    endfunction

    function automatic dir_row_t row(input logic op, input int size, input int off,
                                     input bit typed, input bit ok, input int at);
        dir_row_t d;
        d.req.operation = op;
        d.req.request_size = bnfa_pkg::SIZE_W'(size);
        d.req.free_offset = bnfa_pkg::OFFS_W'(off);
        d.typed = typed;
        d.want.success = ok;
        d.want.alloc_offset = bnfa_pkg::OFFS_W'(at);
        return d;
    endfunction

    function automatic bnfa_pkg::req_beat_t pick_request();
        bnfa_pkg::req_beat_t b;
        live_run_t lr;
        int r, k, pick, fill;
        b.operation = bnfa_pkg::OP_ALLOC;
        b.request_size = '0;
        b.free_offset = bnfa_pkg::OFFS_W'($urandom_range(UNITS - 1));
        r = $urandom_range(99);
        fill = $countones(occ_map);
        if (r < 5) begin
            b.operation = 1'($urandom_range(1));
            b.request_size = bnfa_pkg::SIZE_W'($urandom_range(2047));
        end else if (live_runs.size() > 0 && (r < 45 || fill > 870)) begin
            b.operation = bnfa_pkg::OP_FREE;
            k = $urandom_range(99);
            pick = $urandom_range(live_runs.size() - 1);
            lr = live_runs[pick];
            if (k < 70) begin
                b.free_offset = bnfa_pkg::OFFS_W'(lr.base);
                b.request_size = bnfa_pkg::SIZE_W'(lr.len);
                live_runs.delete(pick);
            end else if (k < 85) begin
                b.free_offset = bnfa_pkg::OFFS_W'(
                    (fit_ptr + UNITS - int'($urandom_range(1, 64))) % UNITS);
                b.request_size = bnfa_pkg::SIZE_W'($urandom_range(1, 128));
            end else begin
                b.free_offset = bnfa_pkg::OFFS_W'(lr.base + int'($urandom_range(lr.len - 1)));
                b.request_size = bnfa_pkg::SIZE_W'($urandom_range(1, lr.len));
            end
        end else begin
            k = $urandom_range(99);
            if (k < 70) b.request_size = bnfa_pkg::SIZE_W'($urandom_range(1, 32));
            else if (k < 90) b.request_size = bnfa_pkg::SIZE_W'($urandom_range(33, 128));
            else if (k < 97) b.request_size = bnfa_pkg::SIZE_W'($urandom_range(129, 400));
            else b.request_size = bnfa_pkg::SIZE_W'($urandom_range(401, UNITS));
        end
        return b;
    endfunction

    task automatic drive_request(input bnfa_pkg::req_beat_t b, input bit typed,
                                 input bnfa_pkg::rsp_beat_t want);
        int gap;
        bnfa_pkg::rsp_beat_t p;
        gap = 0;
        if (!quiet) begin
            while ($urandom_range(99) < 6) gap++;
        end
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_beat <= b;
        do @(posedge aclk); while (!s_ready);
        p = predict_beat(b);
        rsp_expect.push_back(typed ? want : p);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (rsp_expect.size() != 0);
    endtask

    // response side: ready throttling, long hold-offs and scoring
    initial begin
        int hold_left;
        int hold_idx;
        bnfa_pkg::rsp_beat_t got;
        bnfa_pkg::rsp_beat_t want;
        hold_left = 0;
        hold_idx = 0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                got = m_beat;
                if (rsp_expect.size() == 0) begin
                    $error("unexpected response beat: success %0d, alloc_offset %0d",
                           got.success, got.alloc_offset);
                    mismatches++;
                end else begin
                    want = rsp_expect.pop_front();
                    if (got.success !== want.success) begin
                        $error("success: expected %0d, actual %0d", want.success, got.success);
                        mismatches++;
                    end
                    if (got.alloc_offset !== want.alloc_offset) begin
                        $error("alloc_offset: expected %0d, actual %0d",
                               want.alloc_offset, got.alloc_offset);
                        mismatches++;
                    end
                end
                results_seen++;
            end
            if (hold_left == 0 && ((hold_idx == 0 && results_seen >= 300) ||
                                   (hold_idx == 1 && results_seen >= 1100))) begin
                hold_left = HOLD_CYCLES;
                hold_idx++;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= quiet || ($urandom_range(99) >= 6);
            end
        end
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge aclk);
            cycles++;
            if (cycles >= CYCLE_LIMIT) begin
                $display("timeout after %0d cycles, %0d beats outstanding",
                         cycles, rsp_expect.size());
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    initial begin
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_beat <= '0;
        occ_map = '0;
        fit_ptr = 0;
        quiet = 1'b0;

        directed_rows.push_back(row(bnfa_pkg::OP_ALLOC,    0,    0, 1, 0,   0));
        directed_rows.push_back(row(bnfa_pkg::OP_FREE,     0,    0, 1, 0,   0));
        directed_rows.push_back(row(bnfa_pkg::OP_ALLOC, 1025, 1023, 1, 0,   0));
        directed_rows.push_back(row(bnfa_pkg::OP_ALLOC, 2047,    0, 1, 0,   0));
        directed_rows.push_back(row(bnfa_pkg::OP_ALLOC,    1,    0, 1, 1,   0));
        directed_rows.push_back(row(bnfa_pkg::OP_ALLOC, 1024,    0, 1, 0,   0));
        directed_rows.push_back(row(bnfa_pkg::OP_FREE,     1,    0, 1, 1,   0));
        directed_rows.push_back(row(bnfa_pkg::OP_ALLOC, 1024,    0, 0, 0,   0));
        directed_rows.push_back(row(bnfa_pkg::OP_ALLOC,    1,    0, 1, 0,   0));
        directed_rows.push_back(row(bnfa_pkg::OP_FREE,  2047, 1023, 1, 1,   0));
        directed_rows.push_back(row(bnfa_pkg::OP_FREE,     1,  512, 1, 1,   0));
        directed_rows.push_back(row(bnfa_pkg::OP_FREE,     1,  512, 1, 1,   0));
        directed_rows.push_back(row(bnfa_pkg::OP_FREE,  1024,    0, 1, 1,   0));
        directed_rows.push_back(row(bnfa_pkg::OP_ALLOC, 1024, 1023, 1, 1,   0));
        directed_rows.push_back(row(bnfa_pkg::OP_FREE,  1024,    0, 1, 1,   0));
        directed_rows.push_back(row(bnfa_pkg::OP_ALLOC,  100,    0, 1, 1,   0));
        directed_rows.push_back(row(bnfa_pkg::OP_ALLOC,   50,    0, 1, 1, 100));
        directed_rows.push_back(row(bnfa_pkg::OP_FREE,   140,    0, 1, 1,   0));
        directed_rows.push_back(row(bnfa_pkg::OP_ALLOC, 1000,    0, 1, 0,   0));
        directed_rows.push_back(row(bnfa_pkg::OP_FREE,    10,  140, 1, 1,   0));
        directed_rows.push_back(row(bnfa_pkg::OP_ALLOC,  900,    0, 0, 0,   0));
        directed_rows.push_back(row(bnfa_pkg::OP_FREE,     1, 1023, 1, 1,   0));
        directed_rows.push_back(row(bnfa_pkg::OP_ALLOC,  124, 1023, 0, 0,   0));
        directed_rows.push_back(row(bnfa_pkg::OP_FREE,  1024,    0, 1, 1,   0));

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i])
            drive_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);
        wait_drained();

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            quiet = (n >= 500 && n < 800);
            if (n == 900) wait_drained();
            drive_request(pick_request(), 1'b0, '0);
        end
        quiet = 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("%0d responses in %0d cycles: %0d runs placed (%0d across the pointer),",
                 results_seen, cycles, allocs_ok, joined_allocs);
        $display("%0d allocations refused, %0d runs released", allocs_failed, frees_done);
        if (mismatches == 0 && rsp_expect.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
